// ===== rtl/slx_pkg.sv =====
// Shared types, instruction codes and heading tables for the stack language execute unit.
// Used by slx_ctrl, slx_dp and stack_language_execute_unit_top; depends on nothing.
package slx_pkg;

    // Instruction bytes
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BACK  = 8'h5C;
    localparam logic [7:0] CH_REV   = 8'h78;
    localparam logic [7:0] CH_AUP   = 8'h5E;
    localparam logic [7:0] CH_ADOWN = 8'h76;
    localparam logic [7:0] CH_ALEFT = 8'h3C;
    localparam logic [7:0] CH_ARGHT = 8'h3E;
    localparam logic [7:0] CH_SKIP  = 8'h23;
    localparam logic [7:0] CH_END   = 8'h40;
    localparam logic [7:0] CH_RDNUM = 8'h26;
    localparam logic [7:0] CH_RDCHR = 8'h7E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LIST  = 8'h3D;
    localparam logic [7:0] CH_OUTC  = 8'h2C;
    localparam logic [7:0] CH_OUTN  = 8'h2E;
    localparam logic [7:0] CH_INC   = 8'h29;
    localparam logic [7:0] CH_DEC   = 8'h28;
    localparam logic [7:0] CH_DUP   = 8'h3A;
    localparam logic [7:0] CH_NOT   = 8'h21;
    localparam logic [7:0] CH_DROP  = 8'h24;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h7C;
    localparam logic [7:0] CH_SWAP  = 8'h3B;
    localparam logic [7:0] CH_GT    = 8'h60;
    localparam logic [7:0] CH_ROT   = 8'h72;
    localparam logic [7:0] CH_DSWAP = 8'h73;
    localparam logic [7:0] CH_PICK  = 8'h67;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;
    localparam logic [7:0] CH_HA    = 8'h61;
    localparam logic [7:0] CH_HF    = 8'h66;

    // Headings; SUPER marks a conditional turn that pops the stack
    localparam logic [2:0] H_RIGHT = 3'd0;
    localparam logic [2:0] H_UP    = 3'd1;
    localparam logic [2:0] H_LEFT  = 3'd2;
    localparam logic [2:0] H_DOWN  = 3'd3;
    localparam logic [2:0] H_SUPER = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_NUM  = 2'd2;
    localparam logic [1:0] KIND_LIST = 2'd3;

    // Instruction class, latched when an instruction is taken
    typedef enum logic [3:0] {
        CL_PLAIN, CL_TEXT, CL_HALTED, CL_MUL, CL_DIV, CL_SWAP,
        CL_ROT, CL_DSWAP, CL_PICK, CL_LIST, CL_SKIP
    } cls_t;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        DP_NOP, DP_LOAD, DP_RD_TOP, DP_RD_SEC, DP_CAP_B, DP_MUL, DP_DIV_INIT,
        DP_DIV, DP_EXEC, DP_SWAP2, DP_DEEP_RD, DP_DEEP_CAP, DP_ROT_RD,
        DP_ROT_WR, DP_DEEP_FIN, DP_MOVE, DP_REDUCE, DP_LIST_RD, DP_LIST_EMIT,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } slx_cmd_t;

    typedef struct packed {
        cls_t cls;
        logic ge2;
        logic mul_done;
        logic div_done;
        logic deep_ok;
        logic rot_more;
        logic halt;
        logic reduce_done;
        logic list_go;
        logic list_last;
        logic out_free;
    } slx_status_t;

    // New heading for mirrors and arrows, H_SUPER where the stack decides
    function automatic logic [2:0] turn_dir(input logic [7:0] c, input logic [1:0] h);
        logic [2:0] d;
        d = H_RIGHT;
        case (c)
            CH_SLASH: case (h)
                2'd0: d = H_UP;    2'd1: d = H_RIGHT; 2'd2: d = H_DOWN;  default: d = H_LEFT;
            endcase
            CH_BACK: case (h)
                2'd0: d = H_DOWN;  2'd1: d = H_LEFT;  2'd2: d = H_UP;    default: d = H_RIGHT;
            endcase
            CH_AUP: case (h)
                2'd0: d = H_UP;    2'd1: d = H_DOWN;  2'd2: d = H_UP;    default: d = H_SUPER;
            endcase
            CH_ADOWN: case (h)
                2'd0: d = H_DOWN;  2'd1: d = H_SUPER; 2'd2: d = H_DOWN;  default: d = H_UP;
            endcase
            CH_ALEFT: case (h)
                2'd0: d = H_SUPER; 2'd1: d = H_LEFT;  2'd2: d = H_RIGHT; default: d = H_LEFT;
            endcase
            CH_ARGHT: case (h)
                2'd0: d = H_LEFT;  2'd1: d = H_RIGHT; 2'd2: d = H_SUPER; default: d = H_RIGHT;
            endcase
            default: d = {1'b0, h};
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/slx_ctrl.sv =====
// Controller of the stack language execute unit: sequences stack reads, execution,
// iterative units, pointer movement and result transfers. Depends on slx_pkg.
module slx_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  slx_pkg::slx_status_t  status,
    output slx_pkg::slx_cmd_t     cmd
);
    import slx_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RDA, S_RDB, S_CAPB, S_MUL, S_DIVI, S_DIV, S_EXEC, S_SWAP2,
        S_DRD, S_DCAP, S_ROTRD, S_ROTWR, S_FIN, S_MOVE, S_RED, S_LRD, S_LOUT,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   second_reg, second_next;

    // Next state and datapath operation
    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        cmd.op      = DP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op      = DP_LOAD;
                    second_next = 1'b0;
                    state_next  = S_RDA;
                end
            end
            S_RDA:
            begin
                cmd.op     = DP_RD_TOP;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.op     = DP_RD_SEC;
                state_next = S_CAPB;
            end
            S_CAPB:
            begin
                cmd.op = DP_CAP_B;
                if (status.cls == CL_HALTED)
                    state_next = S_EMIT;
                else if (status.cls == CL_MUL && status.ge2)
                    state_next = S_MUL;
                else if (status.cls == CL_DIV && status.ge2)
                    state_next = S_DIVI;
                else
                    state_next = S_EXEC;
            end
            S_MUL:
            begin
                cmd.op = DP_MUL;
                if (status.mul_done)
                    state_next = S_EXEC;
            end
            S_DIVI:
            begin
                cmd.op     = DP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = DP_DIV;
                if (status.div_done)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.op = DP_EXEC;
                if (status.cls == CL_SWAP && status.ge2)
                    state_next = S_SWAP2;
                else if (status.cls inside {CL_ROT, CL_DSWAP, CL_PICK})
                    state_next = S_DRD;
                else
                    state_next = S_MOVE;
            end
            S_SWAP2:
            begin
                cmd.op     = DP_SWAP2;
                state_next = S_MOVE;
            end
            S_DRD:
            begin
                if (status.deep_ok)
                begin
                    cmd.op     = DP_DEEP_RD;
                    state_next = S_DCAP;
                end
                else
                    state_next = S_MOVE;
            end
            S_DCAP:
            begin
                cmd.op     = DP_DEEP_CAP;
                state_next = (status.cls == CL_ROT) ? S_ROTRD : S_FIN;
            end
            S_ROTRD:
            begin
                if (status.rot_more)
                begin
                    cmd.op     = DP_ROT_RD;
                    state_next = S_ROTWR;
                end
                else
                    state_next = S_FIN;
            end
            S_ROTWR:
            begin
                cmd.op     = DP_ROT_WR;
                state_next = S_ROTRD;
            end
            S_FIN:
            begin
                cmd.op     = DP_DEEP_FIN;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                if (status.halt)
                    state_next = S_EMIT;
                else
                begin
                    cmd.op     = DP_MOVE;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                cmd.op = DP_REDUCE;
                if (status.reduce_done)
                begin
                    if (status.cls == CL_SKIP && !second_reg)
                    begin
                        second_next = 1'b1;
                        state_next  = S_MOVE;
                    end
                    else if (status.list_go)
                        state_next = S_LRD;
                    else
                        state_next = S_EMIT;
                end
            end
            S_LRD:
            begin
                cmd.op     = DP_LIST_RD;
                state_next = S_LOUT;
            end
            S_LOUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = DP_LIST_EMIT;
                    state_next = status.list_last ? S_IDLE : S_LRD;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = DP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

endmodule

// ===== rtl/slx_dp.sv =====
// Datapath of the stack language execute unit: stack memory, pointer and heading,
// multiplier and divider steps, and the result register. Depends on slx_pkg.
module slx_dp #(
    parameter int STACK_DEPTH = 32,
    parameter int GRID_MAX    = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  slx_pkg::slx_cmd_t     cmd,
    output slx_pkg::slx_status_t  status,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [8:0]            cfg_data,
    input  logic [7:0]            in_cmd,
    input  logic signed [63:0]    in_number,
    input  logic signed [7:0]     in_char,
    input  logic                  in_available,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [1:0]            out_kind,
    output logic signed [63:0]    out_value,
    output logic [7:0]            out_x,
    output logic [7:0]            out_y,
    output logic                  out_halted,
    output logic                  out_ovf,
    output logic                  out_last
);
    import slx_pkg::*;

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int CNTW = $clog2(STACK_DEPTH + 1);
    localparam int PW   = $clog2(GRID_MAX);
    localparam int CW   = PW + 1;
    localparam int EW   = (CW > 9) ? CW : 9;

    // Grid size with empty and oversize settings clamped
    function automatic logic [CW-1:0] eff_size(input logic [8:0] v);
        logic [EW-1:0] e;
        e = EW'(v);
        if (e == '0)
            return CW'(1);
        if (e > EW'(GRID_MAX))
            return CW'(GRID_MAX);
        return CW'(e);
    endfunction

    // Control state
    logic [8:0]      gw_reg, gw_next, gh_reg, gh_next;
    logic [PW-1:0]   px_reg, px_next, py_reg, py_next;
    logic [1:0]      head_reg, head_next;
    logic            tm_reg, tm_next, halt_reg, halt_next, ovf_reg, ovf_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            ov_reg, ov_next;

    // Payload state
    logic [7:0]      cmd_reg, cmd_next;
    logic [63:0]     num_reg, num_next;
    logic [7:0]      chr_reg, chr_next;
    logic            avail_reg, avail_next;
    cls_t            cls_reg, cls_next;
    logic [63:0]     a_reg, a_next, b_reg, b_next, v_reg, v_next;
    logic [1:0]      kind_reg, kind_next;
    logic [63:0]     val_reg, val_next;
    logic [AW-1:0]   idx_reg, idx_next, j_reg, j_next, li_reg, li_next;
    logic            dok_reg, dok_next;
    logic [CW-1:0]   tx_reg, tx_next, ty_reg, ty_next;
    logic [63:0]     p_reg, p_next;
    logic [31:0]     h_reg, h_next;
    logic [1:0]      ms_reg, ms_next;
    logic [63:0]     dq_reg, dq_next, dr_reg, dr_next, dd_reg, dd_next;
    logic [5:0]      ds_reg, ds_next;
    logic [1:0]      ok_reg, ok_next;
    logic [63:0]     ovl_reg, ovl_next;
    logic [7:0]      ox_reg, ox_next, oy_reg, oy_next;
    logic            oh_reg, oh_next, oo_reg, oo_next, ol_reg, ol_next;

    // Stack memory with one write and one registered read port
    logic [63:0]     mem [STACK_DEPTH];
    logic [63:0]     rdata_reg;
    logic            we, ren;
    logic [AW-1:0]   waddr, raddr;
    logic [63:0]     wdata;

    logic [CW-1:0]   wsz, hsz;
    logic            ge1, ge2;
    logic [63:0]     prod, quot, dsh;
    logic [2:0]      dir;
    logic            push_en;
    logic [63:0]     push_val, k;
    logic [CNTW-1:0] cnt_pop;
    logic            dge;

    assign wsz  = eff_size(gw_reg);
    assign hsz  = eff_size(gh_reg);
    assign ge1  = (cnt_reg != '0);
    assign ge2  = (cnt_reg > CNTW'(1));
    assign prod = {p_reg[63:32] + h_reg, p_reg[31:0]};
    assign quot = (a_reg == '0) ? 64'd0 :
                  ((a_reg[63] ^ b_reg[63]) ? 64'd0 - dq_reg : dq_reg);
    assign dir  = turn_dir(cmd_reg, head_reg);
    assign dsh  = {dr_reg[62:0], dq_reg[63]};
    assign dge  = (dsh >= dd_reg);

    // Status to the controller
    always_comb
    begin
        status.cls         = cls_reg;
        status.ge2         = ge2;
        status.mul_done    = (ms_reg == 2'd2);
        status.div_done    = (ds_reg == 6'd63);
        status.deep_ok     = dok_reg;
        status.rot_more    = (CNTW'(j_reg) + CNTW'(1) < cnt_reg);
        status.halt        = halt_reg;
        status.reduce_done = (tx_reg < wsz) && (ty_reg < hsz);
        status.list_go     = (cls_reg == CL_LIST) && ge1;
        status.list_last   = (CNTW'(li_reg) + CNTW'(1) == cnt_reg);
        status.out_free    = !ov_reg || out_ready;
    end

    // Next-state logic for all operations
    always_comb
    begin
        gw_next = gw_reg;   gh_next = gh_reg;
        px_next = px_reg;   py_next = py_reg;
        head_next = head_reg; tm_next = tm_reg; halt_next = halt_reg; ovf_next = ovf_reg;
        cnt_next = cnt_reg; ov_next = ov_reg;
        cmd_next = cmd_reg; num_next = num_reg; chr_next = chr_reg; avail_next = avail_reg;
        cls_next = cls_reg; a_next = a_reg; b_next = b_reg; v_next = v_reg;
        kind_next = kind_reg; val_next = val_reg;
        idx_next = idx_reg; j_next = j_reg; li_next = li_reg; dok_next = dok_reg;
        tx_next = tx_reg; ty_next = ty_reg;
        p_next = p_reg; h_next = h_reg; ms_next = ms_reg;
        dq_next = dq_reg; dr_next = dr_reg; dd_next = dd_reg; ds_next = ds_reg;
        ok_next = ok_reg; ovl_next = ovl_reg; ox_next = ox_reg; oy_next = oy_reg;
        oh_next = oh_reg; oo_next = oo_reg; ol_next = ol_reg;
        we = 1'b0; waddr = '0; wdata = '0;
        ren = 1'b0; raddr = '0;
        push_en = 1'b0; push_val = '0;
        k = '0; cnt_pop = '0;

        // A transfer on the result side frees the output register
        if (ov_reg && out_ready)
            ov_next = 1'b0;

        // Configuration writes
        if (cfg_we)
        begin
            if (cfg_addr == 1'b0)
                gw_next = cfg_data;
            else
                gh_next = cfg_data;
        end

        case (cmd.op)
            DP_LOAD:
            begin
                cmd_next   = in_cmd;
                num_next   = in_number;
                chr_next   = in_char;
                avail_next = in_available;
                ovf_next   = 1'b0;
                kind_next  = KIND_NONE;
                val_next   = '0;
                li_next    = '0;
                ms_next    = '0;
                dok_next   = 1'b0;
                if (halt_reg)
                    cls_next = CL_HALTED;
                else if (tm_reg)
                    cls_next = CL_TEXT;
                else
                begin
                    case (in_cmd)
                        CH_MUL:   cls_next = CL_MUL;
                        CH_DIV:   cls_next = CL_DIV;
                        CH_SWAP:  cls_next = CL_SWAP;
                        CH_ROT:   cls_next = CL_ROT;
                        CH_DSWAP: cls_next = CL_DSWAP;
                        CH_PICK:  cls_next = CL_PICK;
                        CH_LIST:  cls_next = CL_LIST;
                        CH_SKIP:  cls_next = CL_SKIP;
                        default:  cls_next = CL_PLAIN;
                    endcase
                end
            end
            DP_RD_TOP:
            begin
                ren   = 1'b1;
                raddr = AW'(cnt_reg - CNTW'(1));
            end
            DP_RD_SEC:
            begin
                a_next = rdata_reg;
                ren    = 1'b1;
                raddr  = AW'(cnt_reg - CNTW'(2));
            end
            DP_CAP_B:
                b_next = rdata_reg;
            DP_MUL:
            begin
                // Low half of the product from three 32-bit partial products
                ms_next = ms_reg + 2'd1;
                case (ms_reg)
                    2'd0:    p_next = 64'(b_reg[31:0]) * 64'(a_reg[31:0]);
                    2'd1:    h_next = 32'(b_reg[31:0] * a_reg[63:32]);
                    default: h_next = h_reg + 32'(b_reg[63:32] * a_reg[31:0]);
                endcase
            end
            DP_DIV_INIT:
            begin
                dq_next = b_reg[63] ? 64'd0 - b_reg : b_reg;
                dd_next = a_reg[63] ? 64'd0 - a_reg : a_reg;
                dr_next = '0;
                ds_next = '0;
            end
            DP_DIV:
            begin
                // One quotient bit per cycle, restoring
                ds_next = ds_reg + 6'd1;
                dr_next = dge ? dsh - dd_reg : dsh;
                dq_next = {dq_reg[62:0], dge};
            end
            DP_EXEC:
            begin
                if (tm_reg)
                begin
                    if (cmd_reg == CH_QUOTE)
                        tm_next = 1'b0;
                    else
                    begin
                        push_en  = 1'b1;
                        push_val = {{56{cmd_reg[7]}}, cmd_reg};
                    end
                end
                else
                begin
                    case (cmd_reg) inside
                        CH_SLASH, CH_BACK:
                            head_next = dir[1:0];
                        CH_AUP, CH_ADOWN, CH_ALEFT, CH_ARGHT:
                        begin
                            if (dir == H_SUPER)
                            begin
                                k = ge1 ? a_reg : 64'd0;
                                if (ge1)
                                    cnt_next = cnt_reg - CNTW'(1);
                                if (cmd_reg == CH_AUP || cmd_reg == CH_ADOWN)
                                    head_next = (k == '0) ? H_RIGHT[1:0] : H_LEFT[1:0];
                                else
                                    head_next = (k == '0) ? H_DOWN[1:0] : H_UP[1:0];
                            end
                            else
                                head_next = dir[1:0];
                        end
                        CH_REV:
                            head_next = head_reg + 2'd2;
                        CH_END:
                            halt_next = 1'b1;
                        CH_RDNUM:
                        begin
                            if (!avail_reg)
                                head_next = head_reg + 2'd2;
                            else
                            begin
                                push_en  = 1'b1;
                                push_val = num_reg;
                            end
                        end
                        CH_RDCHR:
                        begin
                            push_en  = 1'b1;
                            push_val = {{56{chr_reg[7]}}, chr_reg};
                        end
                        CH_QUOTE:
                            tm_next = 1'b1;
                        [CH_D0:CH_D9]:
                        begin
                            push_en  = 1'b1;
                            push_val = 64'(8'(cmd_reg - CH_D0));
                        end
                        [CH_HA:CH_HF]:
                        begin
                            push_en  = 1'b1;
                            push_val = 64'(8'(cmd_reg - CH_HA + 8'd10));
                        end
                        CH_OUTC:
                        begin
                            if (ge1)
                            begin
                                kind_next = KIND_CHAR;
                                val_next  = {56'd0, a_reg[7:0]};
                                cnt_next  = cnt_reg - CNTW'(1);
                            end
                        end
                        CH_OUTN:
                        begin
                            if (ge1)
                            begin
                                kind_next = KIND_NUM;
                                val_next  = a_reg;
                                cnt_next  = cnt_reg - CNTW'(1);
                            end
                        end
                        CH_INC, CH_DEC, CH_NOT:
                        begin
                            if (ge1)
                            begin
                                we    = 1'b1;
                                waddr = AW'(cnt_reg - CNTW'(1));
                                if (cmd_reg == CH_INC)
                                    wdata = a_reg + 64'd1;
                                else if (cmd_reg == CH_DEC)
                                    wdata = a_reg - 64'd1;
                                else
                                    wdata = (a_reg == '0) ? 64'd1 : 64'd0;
                            end
                        end
                        CH_DUP:
                        begin
                            if (ge1)
                            begin
                                push_en  = 1'b1;
                                push_val = a_reg;
                            end
                        end
                        CH_DROP:
                        begin
                            if (ge1)
                                cnt_next = cnt_reg - CNTW'(1);
                        end
                        CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_GT:
                        begin
                            if (ge2)
                            begin
                                we       = 1'b1;
                                waddr    = AW'(cnt_reg - CNTW'(2));
                                cnt_next = cnt_reg - CNTW'(1);
                                case (cmd_reg)
                                    CH_ADD:  wdata = b_reg + a_reg;
                                    CH_SUB:  wdata = b_reg - a_reg;
                                    CH_MUL:  wdata = prod;
                                    CH_DIV:  wdata = quot;
                                    default: wdata = ($signed(b_reg) > $signed(a_reg)) ?
                                                     64'd1 : 64'd0;
                                endcase
                            end
                        end
                        CH_SWAP:
                        begin
                            if (ge2)
                            begin
                                we    = 1'b1;
                                waddr = AW'(cnt_reg - CNTW'(1));
                                wdata = b_reg;
                            end
                        end
                        CH_ROT, CH_DSWAP, CH_PICK:
                        begin
                            // Pop the depth, then check it against what remains
                            k        = ge1 ? a_reg : 64'd0;
                            cnt_pop  = ge1 ? cnt_reg - CNTW'(1) : cnt_reg;
                            cnt_next = cnt_pop;
                            dok_next = !k[63] && (k != '0) && (k < 64'(cnt_pop));
                            idx_next = AW'(cnt_pop - CNTW'(1) - k[CNTW-1:0]);
                        end
                        default: ;
                    endcase
                end
            end
            DP_SWAP2:
            begin
                we    = 1'b1;
                waddr = AW'(cnt_reg - CNTW'(2));
                wdata = a_reg;
            end
            DP_DEEP_RD:
            begin
                ren   = 1'b1;
                raddr = idx_reg;
            end
            DP_DEEP_CAP:
            begin
                v_next = rdata_reg;
                j_next = idx_reg;
                if (cls_reg == CL_DSWAP)
                begin
                    we    = 1'b1;
                    waddr = idx_reg;
                    wdata = b_reg;
                end
            end
            DP_ROT_RD:
            begin
                ren   = 1'b1;
                raddr = j_reg + AW'(1);
            end
            DP_ROT_WR:
            begin
                we     = 1'b1;
                waddr  = j_reg;
                wdata  = rdata_reg;
                j_next = j_reg + AW'(1);
            end
            DP_DEEP_FIN:
            begin
                if (cls_reg == CL_PICK)
                begin
                    push_en  = 1'b1;
                    push_val = v_reg;
                end
                else
                begin
                    we    = 1'b1;
                    waddr = AW'(cnt_reg - CNTW'(1));
                    wdata = v_reg;
                end
            end
            DP_MOVE:
            begin
                tx_next = CW'(px_reg);
                ty_next = CW'(py_reg);
                case ({1'b0, head_reg})
                    H_RIGHT: tx_next = CW'(px_reg) + CW'(1);
                    H_UP:    ty_next = CW'(py_reg) + hsz - CW'(1);
                    H_LEFT:  tx_next = CW'(px_reg) + wsz - CW'(1);
                    default: ty_next = CW'(py_reg) + CW'(1);
                endcase
            end
            DP_REDUCE:
            begin
                // Wrap both coordinates, one subtraction of the size a cycle
                if ((tx_reg < wsz) && (ty_reg < hsz))
                begin
                    px_next = PW'(tx_reg);
                    py_next = PW'(ty_reg);
                end
                else
                begin
                    if (tx_reg >= wsz)
                        tx_next = tx_reg - wsz;
                    if (ty_reg >= hsz)
                        ty_next = ty_reg - hsz;
                end
            end
            DP_LIST_RD:
            begin
                ren   = 1'b1;
                raddr = li_reg;
            end
            DP_LIST_EMIT:
            begin
                ov_next  = 1'b1;
                ok_next  = KIND_LIST;
                ovl_next = rdata_reg;
                ox_next  = 8'(px_reg);
                oy_next  = 8'(py_reg);
                oh_next  = halt_reg;
                oo_next  = ovf_reg;
                ol_next  = (CNTW'(li_reg) + CNTW'(1) == cnt_reg);
                li_next  = li_reg + AW'(1);
            end
            DP_EMIT:
            begin
                ov_next  = 1'b1;
                ok_next  = kind_reg;
                ovl_next = val_reg;
                ox_next  = 8'(px_reg);
                oy_next  = 8'(py_reg);
                oh_next  = halt_reg;
                oo_next  = ovf_reg;
                ol_next  = 1'b1;
            end
            default: ;
        endcase

        // Push onto the stack, dropped with a flag when full
        if (push_en)
        begin
            if (cnt_reg == CNTW'(STACK_DEPTH))
                ovf_next = 1'b1;
            else
            begin
                we       = 1'b1;
                waddr    = AW'(cnt_reg);
                wdata    = push_val;
                cnt_next = cnt_reg + CNTW'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg   <= 9'd80;
            gh_reg   <= 9'd25;
            px_reg   <= '0;
            py_reg   <= '0;
            head_reg <= H_RIGHT[1:0];
            tm_reg   <= 1'b0;
            halt_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            gw_reg   <= gw_next;
            gh_reg   <= gh_next;
            px_reg   <= px_next;
            py_reg   <= py_next;
            head_reg <= head_next;
            tm_reg   <= tm_next;
            halt_reg <= halt_next;
            ovf_reg  <= ovf_next;
            cnt_reg  <= cnt_next;
            ov_reg   <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;   num_reg <= num_next;   chr_reg <= chr_next;
        avail_reg <= avail_next; cls_reg <= cls_next;
        a_reg <= a_next;       b_reg <= b_next;       v_reg <= v_next;
        kind_reg <= kind_next; val_reg <= val_next;
        idx_reg <= idx_next;   j_reg <= j_next;       li_reg <= li_next;
        dok_reg <= dok_next;   tx_reg <= tx_next;     ty_reg <= ty_next;
        p_reg <= p_next;       h_reg <= h_next;       ms_reg <= ms_next;
        dq_reg <= dq_next;     dr_reg <= dr_next;     dd_reg <= dd_next;
        ds_reg <= ds_next;
        ok_reg <= ok_next;     ovl_reg <= ovl_next;
        ox_reg <= ox_next;     oy_reg <= oy_next;
        oh_reg <= oh_next;     oo_reg <= oo_next;     ol_reg <= ol_next;
    end

    // Stack memory ports
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (ren)
            rdata_reg <= mem[raddr];
    end

    assign out_valid  = ov_reg;
    assign out_kind   = ok_reg;
    assign out_value  = ovl_reg;
    assign out_x      = ox_reg;
    assign out_y      = oy_reg;
    assign out_halted = oh_reg;
    assign out_ovf    = oo_reg;
    assign out_last   = ol_reg;

endmodule

// ===== rtl/stack_language_execute_unit_top.sv =====
// Top level of the stack language execute unit: stream ports, configuration port,
// controller and datapath. Depends on slx_pkg, slx_ctrl and slx_dp.
//
//  Channel   Direction  Contents
//  s_axis    in         one instruction byte with its input values
//  m_axis    out        one or more results per instruction, tlast on the final one
//  cfg       in         grid width (index 0) and grid height (index 1)
//
// A plain instruction passes through accept, two stack reads, capture, execute, move,
// wrap check and result; each wrap subtraction adds a step. '*' adds multiplier steps,
// '|' a divider start and a step per quotient bit, ';' a second write, '#' a second move
// and wrap check. 'r', 's' and 'g' add a depth check, plus a deep read, capture and a
// final step with a valid depth; 'r' then shifts each element. '=' lists each element.
// Reset clears pointer, heading, modes and stack count; the stack memory needs no
// clearing. A stalled result holds the output register; the next instruction is
// taken meanwhile and waits only when its own result is ready.
module stack_language_execute_unit_top #(
    parameter int STACK_DEPTH = 32,
    parameter int GRID_MAX    = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] cmd, [71:8] in_number, [79:72] in_char, [80] in_available, [87:81] zero
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [63:0] out_value, [71:64] next_x, [79:72] next_y, [80] halted, [81] overflow,
    // [87:82] zero
    output logic [87:0] m_axis_tdata,
    // [1:0] out_kind
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [8:0]  cfg_data
);
    import slx_pkg::*;

    slx_cmd_t    cmd;
    slx_status_t status;
    logic [63:0] out_value;
    logic [7:0]  out_x, out_y;
    logic        out_halted, out_ovf;

    slx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    slx_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .GRID_MAX    (GRID_MAX)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .in_cmd       (s_axis_tdata[7:0]),
        .in_number    (s_axis_tdata[71:8]),
        .in_char      (s_axis_tdata[79:72]),
        .in_available (s_axis_tdata[80]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_kind     (m_axis_tuser),
        .out_value    (out_value),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_halted   (out_halted),
        .out_ovf      (out_ovf),
        .out_last     (m_axis_tlast)
    );

    // Result fields packed from the lowest bit up
    assign m_axis_tdata = {6'd0, out_ovf, out_halted, out_y, out_x, out_value};

endmodule

// ===== sim/stack_language_execute_unit_top_tb.sv =====
// Self-checking testbench for the stack language execute unit.
// Depends on slx_pkg and stack_language_execute_unit_top; a behavioural model predicts every result.
`timescale 1ns / 1ps

module stack_language_execute_unit_top_tb;
    import slx_pkg::*;

    localparam int DEPTH = 32;
    localparam int GMAX  = 256;
    localparam int CYCLE_LIMIT = 2000000;

    localparam logic [7:0] CH_D1_KEY = 8'h31;
    localparam logic [7:0] CH_D2_KEY = 8'h32;
    localparam logic [7:0] CH_D3_KEY = 8'h33;
    localparam logic [7:0] CH_RAND   = 8'h3F;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] value;
        logic [7:0]  x;
        logic [7:0]  y;
        logic        halted;
        logic        ovf;
        logic        last;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic        cfg_addr;
    logic [8:0]  cfg_data;

    // Model state of the execute unit
    int          mx, my;
    logic [1:0]  mhead;
    logic        mtext, mhalt, movf;
    logic [63:0] mstack [DEPTH];
    int          mcount;
    logic [8:0]  mwidth, mheight;

    result_t     expected_q[$];
    int          errors;
    int          cycles;

    stack_language_execute_unit_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    // Clock and the run-time watchdog.
    initial
    begin
        clk = 1'b0;
        cycles = 0;
        forever
        begin
            #5 clk = ~clk;
            if (clk)
            begin
                cycles = cycles + 1;
                if (cycles > CYCLE_LIMIT)
                begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    function automatic int grid_size(input logic [8:0] v);
        if (v == 0)
            return 1;
        if (v > GMAX)
            return GMAX;
        return int'(v);
    endfunction

    function automatic logic [2:0] new_heading(input logic [7:0] c, input logic [1:0] h);
        logic [2:0] d;
        d = {1'b0, h};
        case (c)
            CH_SLASH: d = (h == 0) ? H_UP : (h == 1) ? H_RIGHT : (h == 2) ? H_DOWN : H_LEFT;
            CH_BACK:  d = (h == 0) ? H_DOWN : (h == 1) ? H_LEFT : (h == 2) ? H_UP : H_RIGHT;
            CH_AUP:   d = (h == 0) ? H_UP : (h == 1) ? H_DOWN : (h == 2) ? H_UP : H_SUPER;
            CH_ADOWN: d = (h == 0) ? H_DOWN : (h == 1) ? H_SUPER : (h == 2) ? H_DOWN : H_UP;
            CH_ALEFT: d = (h == 0) ? H_SUPER : (h == 1) ? H_LEFT : (h == 2) ? H_RIGHT : H_LEFT;
            CH_ARGHT: d = (h == 0) ? H_LEFT : (h == 1) ? H_RIGHT : (h == 2) ? H_SUPER : H_RIGHT;
            default: d = {1'b0, h};
        endcase
        return d;
    endfunction

    function automatic logic [63:0] div_trunc(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ua, ub, q;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        if (ub == 0)
            return 64'd0;
        q = ua / ub;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    task automatic stack_push(input logic [63:0] v);
        if (mcount >= DEPTH)
            movf = 1'b1;
        else
        begin
            mstack[mcount] = v;
            mcount = mcount + 1;
        end
    endtask

    task automatic stack_pop(output logic [63:0] v);
        v = 64'd0;
        if (mcount > 0)
        begin
            mcount = mcount - 1;
            v = mstack[mcount];
        end
    endtask

    task automatic advance_pointer();
        int w, h;
        w = grid_size(mwidth);
        h = grid_size(mheight);
        case (mhead)
            2'd0: mx = mx + 1;
            2'd1: my = my + h - 1;
            2'd2: mx = mx + w - 1;
            default: my = my + 1;
        endcase
        mx = mx % w;
        my = my % h;
    endtask

    task automatic add_result(input logic [1:0] kind, input logic [63:0] v, input logic lst);
        result_t r;
        r.kind = kind;
        r.value = v;
        r.x = mx[7:0];
        r.y = my[7:0];
        r.halted = mhalt;
        r.ovf = movf;
        r.last = lst;
        expected_q = {expected_q, r};
    endtask

    // Executes one instruction on the model and queues the results it causes.
    task automatic predict_instruction(input logic [87:0] d);
        logic [7:0]  c;
        logic [63:0] t, a, b, v;
        logic [2:0]  nh;
        logic [1:0]  kind;
        logic [63:0] val;
        logic        listing;
        int          idx, j;
        c = d[7:0];
        kind = KIND_NONE;
        val = 64'd0;
        listing = 1'b0;
        movf = 1'b0;
        if (mhalt)
        begin
            add_result(KIND_NONE, 64'd0, 1'b1);
            return;
        end
        if (mtext)
        begin
            if (c == CH_QUOTE)
                mtext = 1'b0;
            else
                stack_push({{56{c[7]}}, c});
        end
        else
        begin
            case (c)
                CH_REV:   mhead = mhead + 2'd2;
                CH_SKIP:  advance_pointer();
                CH_END:   mhalt = 1'b1;
                CH_RDNUM:
                    if (!d[80])
                        mhead = mhead + 2'd2;
                    else
                        stack_push(d[71:8]);
                CH_RDCHR: stack_push({{56{d[79]}}, d[79:72]});
                CH_QUOTE: mtext = 1'b1;
                CH_LIST:  listing = 1'b1;
                CH_SLASH, CH_BACK, CH_AUP, CH_ADOWN, CH_ALEFT, CH_ARGHT:
                begin
                    nh = new_heading(c, mhead);
                    if (nh == H_SUPER)
                    begin
                        stack_pop(t);
                        if (c == CH_AUP || c == CH_ADOWN)
                            nh = (t == 0) ? H_RIGHT : H_LEFT;
                        else
                            nh = (t == 0) ? H_DOWN : H_UP;
                    end
                    mhead = nh[1:0];
                end
                default: ;
            endcase
            if (c >= CH_D0 && c <= CH_D9)
                stack_push(64'(c - CH_D0));
            else if (c >= CH_HA && c <= CH_HF)
                stack_push(64'(c - CH_HA + 10));

            // Single-operand instructions
            if (mcount >= 1)
            begin
                t = mstack[mcount - 1];
                case (c)
                    CH_OUTC: begin kind = KIND_CHAR; val = {56'd0, t[7:0]}; mcount--; end
                    CH_OUTN: begin kind = KIND_NUM; val = t; mcount--; end
                    CH_INC:  mstack[mcount - 1] = t + 1;
                    CH_DEC:  mstack[mcount - 1] = t - 1;
                    CH_DUP:  stack_push(t);
                    CH_NOT:  mstack[mcount - 1] = (t == 0) ? 64'd1 : 64'd0;
                    CH_DROP: mcount--;
                    default: ;
                endcase
            end

            // Two-operand instructions
            if (mcount >= 2)
            begin
                a = mstack[mcount - 1];
                b = mstack[mcount - 2];
                case (c)
                    CH_ADD: begin mstack[mcount - 2] = b + a; mcount--; end
                    CH_SUB: begin mstack[mcount - 2] = b - a; mcount--; end
                    CH_MUL: begin mstack[mcount - 2] = b * a; mcount--; end
                    CH_DIV: begin mstack[mcount - 2] = div_trunc(b, a); mcount--; end
                    CH_SWAP:
                    begin
                        mstack[mcount - 1] = b;
                        mstack[mcount - 2] = a;
                    end
                    CH_GT:
                    begin
                        mstack[mcount - 2] = ($signed(b) > $signed(a)) ? 64'd1 : 64'd0;
                        mcount--;
                    end
                    default: ;
                endcase
            end

            // Rotate, deep swap and pick address the element k below the top
            if (c == CH_ROT || c == CH_DSWAP || c == CH_PICK)
            begin
                stack_pop(t);
                if (!t[63] && t != 0 && t < 64'(mcount))
                begin
                    idx = mcount - 1 - int'(t);
                    v = mstack[idx];
                    if (c == CH_ROT)
                    begin
                        for (j = idx; j < mcount - 1; j++)
                            mstack[j] = mstack[j + 1];
                        mstack[mcount - 1] = v;
                    end
                    else if (c == CH_DSWAP)
                    begin
                        mstack[idx] = mstack[mcount - 1];
                        mstack[mcount - 1] = v;
                    end
                    else
                        stack_push(v);
                end
            end
        end
        if (!mhalt)
            advance_pointer();

        if (listing && mcount > 0)
        begin
            for (j = 0; j < mcount; j++)
                add_result(KIND_LIST, mstack[j], j == mcount - 1);
        end
        else
            add_result(kind, val, 1'b1);
    endtask

    // Sends one instruction; the valid stays high when the next one follows at once.
    task automatic send_instruction(input logic [7:0] c, input logic [63:0] num,
                                    input logic [7:0] ch, input logic avail);
        logic [87:0] d;
        int gap;
        d = {7'd0, avail, ch, num, c};
        predict_instruction(d);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        gap = 0;
        if ($urandom % 3 == 0)
            gap = ($urandom % 10 == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_cmd(input logic [7:0] c);
        send_instruction(c, {$urandom, $urandom}, 8'($urandom), 1'($urandom));
    endtask

    task automatic push_number(input logic [63:0] v);
        send_instruction(CH_RDNUM, v, 8'($urandom), 1'b1);
    endtask

    // Waits until every expected result has arrived and the block has settled.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_grid(input logic [8:0] w, input logic [8:0] h);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_addr <= 1'b0;
        cfg_data <= w;
        @(posedge clk);
        cfg_addr <= 1'b1;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        mwidth = w;
        mheight = h;
    endtask

    // Division corner cases, wrapping arithmetic, compare and outputs.
    task automatic test_arithmetic();
        push_number(64'h8000_0000_0000_0000);
        push_number(64'hFFFF_FFFF_FFFF_FFFF);
        send_cmd(CH_DIV);
        send_cmd(CH_OUTN);
        push_number(64'd7);
        send_cmd(CH_D0);
        send_cmd(CH_DIV);
        send_cmd(CH_OUTN);
        push_number(-64'sd7);
        send_cmd(CH_D2_KEY);
        send_cmd(CH_DIV);
        push_number(64'h7FFF_FFFF_FFFF_FFFF);
        send_cmd(CH_HF);
        send_cmd(CH_MUL);
        send_cmd(CH_GT);
        send_cmd(CH_NOT);
        send_cmd(CH_DEC);
        send_cmd(CH_OUTC);
        send_cmd(CH_ADD);
    endtask

    // Arrows on an empty stack, text mode, input reads and the stack listing.
    task automatic test_flow_and_io();
        send_cmd(CH_ARGHT);
        send_cmd(CH_AUP);
        send_cmd(CH_ADOWN);
        send_cmd(CH_ALEFT);
        send_instruction(CH_RDNUM, 64'd5, 8'h00, 1'b0);
        send_instruction(CH_RDCHR, 64'd0, 8'hFF, 1'b1);
        send_instruction(CH_RDCHR, 64'd0, 8'h80, 1'b1);
        send_cmd(CH_QUOTE);
        send_cmd(8'hFF);
        send_cmd(8'h41);
        send_cmd(CH_QUOTE);
        send_cmd(CH_D3_KEY);
        send_cmd(CH_ROT);
        send_cmd(CH_D1_KEY);
        send_cmd(CH_DSWAP);
        send_cmd(CH_PICK);
        send_cmd(CH_LIST);
        send_cmd(CH_SKIP);
        send_cmd(CH_SLASH);
        send_cmd(CH_BACK);
        send_cmd(CH_REV);
        send_cmd(CH_RAND);
    endtask

    // Fills the stack past its depth, lists it full, then empties it.
    task automatic test_overflow();
        int i;
        for (i = 0; i < DEPTH + 2; i++)
            send_cmd(CH_D9);
        send_cmd(CH_DUP);
        send_cmd(CH_LIST);
        for (i = 0; i < DEPTH + 1; i++)
            send_cmd(CH_DROP);
        send_cmd(CH_LIST);
    endtask

    // One random instruction, mostly well-formed stack programs.
    task automatic random_instruction();
        logic [7:0] ops [26];
        logic [7:0] c;
        int pick;
        ops = '{CH_OUTC, CH_OUTN, CH_INC, CH_DEC, CH_DUP, CH_NOT, CH_DROP, CH_ADD,
                CH_SUB, CH_MUL, CH_DIV, CH_SWAP, CH_GT, CH_ROT, CH_DSWAP, CH_PICK,
                CH_LIST, CH_SLASH, CH_BACK, CH_REV, CH_AUP, CH_ADOWN, CH_ALEFT,
                CH_ARGHT, CH_SKIP, CH_QUOTE};
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            c = 8'($urandom_range(0, 15));
            c = (c < 8'd10) ? CH_D0 + c : CH_HA + c - 8'd10;
            send_cmd(c);
        end
        else if (pick < 40)
        begin
            if ($urandom % 2)
                push_number({$urandom, $urandom});
            else
                send_instruction(CH_RDNUM, 64'($signed($urandom_range(0, 20)) - 10),
                                 8'($urandom), ($urandom % 5) != 0);
        end
        else if (pick < 45)
            send_cmd(CH_RDCHR);
        else if (pick < 88)
            send_cmd(ops[$urandom_range(0, 25)]);
        else
        begin
            // Arbitrary byte, avoiding the end instruction
            c = 8'($urandom);
            if (c == CH_END)
                c = CH_SPACE;
            send_cmd(c);
        end
    endtask

    task automatic test_random(input int count);
        int i;
        for (i = 0; i < count; i++)
            random_instruction();
    endtask

    // End instruction, then steps that only report the halted state.
    task automatic test_halt();
        send_cmd(CH_D2_KEY);
        send_cmd(CH_END);
        send_cmd(CH_DUP);
        send_cmd(CH_LIST);
        send_cmd(CH_OUTN);
    endtask

    // Result side: random back-pressure.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(posedge clk);
            if ($urandom % 4 == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (($urandom % 10 == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3))
                    @(posedge clk);
            end
            else
                @(posedge clk);
        end
    end

    // Compares each result transfer with the oldest expectation.
    initial
    begin
        result_t e;
        errors = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result tdata=%h kind=%0d", $time,
                             m_axis_tdata, m_axis_tuser);
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (m_axis_tuser !== e.kind || m_axis_tdata[63:0] !== e.value ||
                        m_axis_tdata[71:64] !== e.x || m_axis_tdata[79:72] !== e.y ||
                        m_axis_tdata[80] !== e.halted || m_axis_tdata[81] !== e.ovf ||
                        m_axis_tlast !== e.last)
                    begin
                        $display("%0t: expected kind=%0d value=%h x=%0d y=%0d halt=%b ovf=%b last=%b",
                                 $time, e.kind, e.value, e.x, e.y, e.halted, e.ovf, e.last);
                        $display("%0t: actual   kind=%0d value=%h x=%0d y=%0d halt=%b ovf=%b last=%b",
                                 $time, m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[71:64],
                                 m_axis_tdata[79:72], m_axis_tdata[80], m_axis_tdata[81],
                                 m_axis_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        int i;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = 1'b0;
        cfg_data = '0;
        mx = 0;
        my = 0;
        mhead = 2'd0;
        mtext = 1'b0;
        mhalt = 1'b0;
        movf = 1'b0;
        mcount = 0;
        mwidth = 9'd80;
        mheight = 9'd25;
        for (i = 0; i < DEPTH; i++)
            mstack[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_arithmetic();
        test_flow_and_io();
        write_grid(9'd3, 9'd2);
        test_overflow();
        write_grid(9'd1, 9'd1);
        test_random(9);
        write_grid(9'd256, 9'd256);
        test_random(9);
        write_grid(9'd0, 9'd511);
        test_random(9);
        write_grid(9'd511, 9'd5);
        test_random(9);
        write_grid(9'd80, 9'd25);
        test_random(9);
        test_halt();

        wait_idle();
        if (errors == 0 && expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
